>>> rtl/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared types and constants of the running mean and deviation unit.
// ----------------------------------------------------------------------------
package rmsd_pkg;

   localparam int DATA_W  = 24;
   localparam int COUNT_W = 16;
   localparam int SUM_W   = 40;
   localparam int SQ_W    = 64;
   localparam int PROD_W  = 80;
   localparam int DEN_W   = 32;
   localparam int QUO_W   = 64;
   localparam int STEP_W  = 7;

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   // Totals of one finished set, handed from the front to the back.
   typedef struct packed {
      logic [COUNT_W-1:0]       count;
      logic signed [SUM_W-1:0]  sum;
      logic [SQ_W-1:0]          square_sum;
      logic                     overflow;
   } snapshot_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MEAN,
      BK_MUL_A,
      BK_MUL_B,
      BK_DIV,
      BK_SQRT,
      BK_DONE
   } back_state_type;

endpackage

>>> rtl/rmsd_front.sv
// ----------------------------------------------------------------------------
// rmsd_front
// Takes in samples, skips missing ones and keeps the running totals.
// ----------------------------------------------------------------------------
module rmsd_front import rmsd_pkg::*; #(
   parameter int MAX_COUNT    = 65535,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DATA_W-1:0]   csr_missing_value,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [DATA_W-1:0]   req_sample,
   input  logic                req_last,
   input  logic                queue_full,
   output logic                push_valid,
   output snapshot_type        push_data
);

   localparam int SHIFT = DATA_W - SAMPLE_WIDTH;
   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(MAX_COUNT);

   logic [DATA_W-1:0]        missing_ff, missing_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]          square_ff, square_in;
   logic                     ovf_ff, ovf_in;

   logic signed [DATA_W-1:0]   s_hi, m_hi, s_val, m_val;
   logic signed [2*DATA_W-1:0] s_square;
   logic                       accept, take;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Sign-extend sample and missing value from the configured width.
   assign s_hi     = $signed(req_sample) <<< SHIFT;
   assign m_hi     = $signed(missing_ff) <<< SHIFT;
   assign s_val    = s_hi >>> SHIFT;
   assign m_val    = m_hi >>> SHIFT;
   assign s_square = s_val * s_val;
   assign take     = accept && (s_val != m_val);

   // Running totals; the count saturates and flags the overflow.
   always_comb begin
      missing_in = missing_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      square_in  = square_ff;
      ovf_in     = ovf_ff;
      if (csr_valid && csr_ready) begin
         missing_in = csr_missing_value;
      end
      if (take) begin
         if (count_ff >= CAP) begin
            ovf_in = 1'b1;
         end else begin
            count_in  = count_ff + 1'b1;
            sum_in    = sum_ff + SUM_W'(s_val);
            square_in = square_ff + SQ_W'($unsigned(s_square));
         end
      end
   end

   // A last request hands the totals over and starts a new set.
   assign push_valid            = accept && req_last;
   assign push_data.count       = count_in;
   assign push_data.sum         = sum_in;
   assign push_data.square_sum  = square_in;
   assign push_data.overflow    = ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         missing_ff <= '0;
         count_ff   <= '0;
         sum_ff     <= '0;
         square_ff  <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         missing_ff <= missing_in;
         if (push_valid) begin
            count_ff  <= '0;
            sum_ff    <= '0;
            square_ff <= '0;
            ovf_ff    <= 1'b0;
         end else begin
            count_ff  <= count_in;
            sum_ff    <= sum_in;
            square_ff <= square_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

endmodule

>>> rtl/rmsd_queue.sv
// ----------------------------------------------------------------------------
// rmsd_queue
// Two-entry queue of finished set totals between front and back.
// ----------------------------------------------------------------------------
module rmsd_queue import rmsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  snapshot_type  push_data,
   output logic          full,
   output logic          pop_valid,
   input  logic          pop,
   output snapshot_type  pop_data
);

   snapshot_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         do_push, do_pop;

   assign full      = (fill_ff == 2'd2);
   assign pop_valid = (fill_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> rtl/rmsd_back.sv
// ----------------------------------------------------------------------------
// rmsd_back
// Bit-serial mean division, variance numerator, variance division and
// square root for one set, followed by the response register.
// ----------------------------------------------------------------------------
module rmsd_back import rmsd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  snapshot_type        pop_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_mean_value,
   output logic [DATA_W-1:0]   rsp_std_dev,
   output logic [COUNT_W-1:0]  rsp_valid_count,
   output logic [1:0]          rsp_status
);

   back_state_type state_ff, state_in;

   logic [COUNT_W-1:0]  n_ff, n_in;
   logic                neg_ff, neg_in;
   logic [SUM_W-1:0]    mag_ff, mag_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic                ovf_ff, ovf_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [PROD_W-1:0]   work_ff, work_in;
   logic [PROD_W-1:0]   shf_ff, shf_in;
   logic [PROD_W-1:0]   diff_ff, diff_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DATA_W-1:0]   mean_ff, mean_in;
   logic [QUO_W-1:0]    sx_ff, sx_in, sres_ff, sres_in, sbit_ff, sbit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   mean_out_ff, sd_out_ff;
   logic [COUNT_W-1:0]  count_out_ff;
   status_type          status_out_ff;

   logic                last_step, out_load;
   logic [COUNT_W:0]    mean_trial;
   logic [DEN_W:0]      div_trial;
   logic                qbit;
   logic [QUO_W-1:0]    qnext, sq_try;
   logic [PROD_W-1:0]   work_next;
   logic [DATA_W-1:0]   qlow;

   // End of the bit-serial pass of the current state.
   always_comb begin
      case (state_ff)
         BK_MEAN:  last_step = (step_ff == STEP_W'(SUM_W - 1));
         BK_MUL_A: last_step = (step_ff == STEP_W'(COUNT_W - 1));
         BK_MUL_B: last_step = (step_ff == STEP_W'(SUM_W - 1));
         BK_DIV:   last_step = (step_ff == STEP_W'(PROD_W - 1));
         BK_SQRT:  last_step = (step_ff == STEP_W'(QUO_W / 2 - 1));
         default:  last_step = 1'b0;
      endcase
   end

   assign out_load = (state_ff == BK_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_data.count == '0) ? BK_DONE : BK_MEAN;
            end
         end
         BK_MEAN: begin
            if (last_step) begin
               state_in = (n_ff == COUNT_W'(1)) ? BK_DONE : BK_MUL_A;
            end
         end
         BK_MUL_A: if (last_step) state_in = BK_MUL_B;
         BK_MUL_B: if (last_step) state_in = BK_DIV;
         BK_DIV:   if (last_step) state_in = BK_SQRT;
         BK_SQRT:  if (last_step) state_in = BK_DONE;
         BK_DONE:  if (out_load) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Shared trial subtract and shift-add terms.
   always_comb begin
      mean_trial = {rem_ff[COUNT_W-1:0], mag_ff[6'(SUM_W - 1) - step_ff[5:0]]};
      div_trial  = {rem_ff, diff_ff[STEP_W'(PROD_W - 1) - step_ff]};
      if (state_ff == BK_MEAN) begin
         qbit = (mean_trial >= {1'b0, n_ff});
      end else begin
         qbit = (div_trial >= {1'b0, den_ff});
      end
      qnext  = {quo_ff[QUO_W-2:0], qbit};
      qlow   = qnext[DATA_W-1:0];
      sq_try = sres_ff + sbit_ff;
      if (state_ff == BK_MUL_A) begin
         work_next = n_ff[step_ff[3:0]] ? work_ff + shf_ff : work_ff;
      end else begin
         work_next = mag_ff[step_ff[5:0]] ? work_ff + shf_ff : work_ff;
      end
   end

   // Datapath per state.
   always_comb begin
      pop     = 1'b0;
      n_in    = n_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      sq_in   = sq_ff;
      ovf_in  = ovf_ff;
      den_in  = den_ff;
      work_in = work_ff;
      shf_in  = shf_ff;
      diff_in = diff_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff + 1'b1;
      mean_in = mean_ff;
      sx_in   = sx_ff;
      sres_in = sres_ff;
      sbit_in = sbit_ff;
      case (state_ff)
         BK_IDLE: begin
            pop     = pop_valid;
            n_in    = pop_data.count;
            neg_in  = pop_data.sum[SUM_W-1];
            mag_in  = pop_data.sum[SUM_W-1] ? -pop_data.sum : pop_data.sum;
            sq_in   = pop_data.square_sum;
            ovf_in  = pop_data.overflow;
            den_in  = DEN_W'(pop_data.count) * DEN_W'(pop_data.count - 1'b1);
            rem_in  = '0;
            quo_in  = '0;
            step_in = '0;
            mean_in = '0;
            sres_in = '0;
         end
         BK_MEAN: begin
            quo_in = qnext;
            rem_in = qbit ? DEN_W'(mean_trial - {1'b0, n_ff}) : DEN_W'(mean_trial);
            if (last_step) begin
               mean_in = neg_ff ? -qlow : qlow;
               step_in = '0;
               work_in = '0;
               shf_in  = PROD_W'(sq_ff);
            end
         end
         BK_MUL_A: begin
            work_in = work_next;
            shf_in  = shf_ff << 1;
            if (last_step) begin
               diff_in = work_next;
               step_in = '0;
               work_in = '0;
               shf_in  = PROD_W'(mag_ff);
            end
         end
         BK_MUL_B: begin
            work_in = work_next;
            shf_in  = shf_ff << 1;
            if (last_step) begin
               diff_in = diff_ff - work_next;
               step_in = '0;
               rem_in  = '0;
               quo_in  = '0;
            end
         end
         BK_DIV: begin
            quo_in = qnext;
            rem_in = qbit ? DEN_W'(div_trial - {1'b0, den_ff}) : DEN_W'(div_trial);
            if (last_step) begin
               step_in = '0;
               sx_in   = qnext;
               sres_in = '0;
               sbit_in = QUO_W'(1) << (QUO_W - 2);
            end
         end
         BK_SQRT: begin
            if (sx_ff >= sq_try) begin
               sx_in   = sx_ff - sq_try;
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
         end
         BK_DONE: begin
            step_in = step_ff;
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
      ovf_ff  <= ovf_in;
      den_ff  <= den_in;
      work_ff <= work_in;
      shf_ff  <= shf_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      mean_ff <= mean_in;
      sx_ff   <= sx_in;
      sres_ff <= sres_in;
      sbit_ff <= sbit_in;
      if (out_load) begin
         mean_out_ff   <= mean_ff;
         sd_out_ff     <= sres_ff[DATA_W-1:0];
         count_out_ff  <= n_ff;
         if (n_ff == '0) begin
            status_out_ff <= ST_EMPTY;
         end else if (ovf_ff) begin
            status_out_ff <= ST_OVERFLOW;
         end else begin
            status_out_ff <= ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_value  = mean_out_ff;
   assign rsp_std_dev     = sd_out_ff;
   assign rsp_valid_count = count_out_ff;
   assign rsp_status      = status_out_ff;

   // An empty set reports all zeros.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_valid_count == '0 && rsp_mean_value == '0 && rsp_std_dev == '0)
      else $error("empty set response carries nonzero fields");

   // A set with samples never reports the empty status.
   a_count_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_count != '0 |-> rsp_status != ST_EMPTY)
      else $error("nonempty set reported as empty");

   // One sample has no deviation.
   a_single_sd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_count == COUNT_W'(1) |-> rsp_std_dev == '0)
      else $error("single sample set has nonzero deviation");

   // The queue is only drained from the idle state.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == BK_IDLE && pop_valid)
      else $error("queue popped outside idle");

endmodule

>>> rtl/running_mean_stddev_unit.sv
// ----------------------------------------------------------------------------
// running_mean_stddev_unit
// Mean and sample standard deviation of sets of signed Q16.8 samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the queue of set totals has room; a
// sample equal to the configured missing value is skipped. The request marked
// last closes a set, and one response follows with the mean (truncated toward
// zero), the sample standard deviation, the valid count and a status. The back
// end works one set at a time with bit-serial units: a 40-step mean division,
// a 16-step and a 40-step shift-add multiply, an 80-step variance division and
// a 32-step square root. A set with a single sample skips all but the mean
// division, and an empty set skips all of them. A two-entry queue of set
// totals sits between the accumulator and the back end, so requests stall
// only when that queue is full.
module running_mean_stddev_unit import rmsd_pkg::*; #(
   parameter int MAX_COUNT    = 65535,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DATA_W-1:0]   csr_missing_value,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [DATA_W-1:0]   req_sample,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_mean_value,
   output logic [DATA_W-1:0]   rsp_std_dev,
   output logic [COUNT_W-1:0]  rsp_valid_count,
   output logic [1:0]          rsp_status
);

   logic         push_valid, queue_full, pop_valid, pop;
   snapshot_type push_data, pop_data;

   // Accumulator front end.
   rmsd_front #(
      .MAX_COUNT    (MAX_COUNT),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_missing_value (csr_missing_value),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_last          (req_last),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_data         (push_data)
   );

   // Queue of closed sets.
   rmsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   // Statistics back end.
   rmsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_std_dev     (rsp_std_dev),
      .rsp_valid_count (rsp_valid_count),
      .rsp_status      (rsp_status)
   );

endmodule
